>>> rtl/srpt_pkg.sv
// Shared constants and types for the shortest-remaining-time queue.
package srpt_pkg;

    localparam int unsigned DefaultDepth = 64;
    localparam int unsigned LenWidth     = 16;
    localparam int unsigned TimeWidth    = 48;
    localparam int unsigned ElapWidth    = 32;
    localparam int unsigned StatWidth    = 64;
    localparam int unsigned OccWidth     = 7;

    typedef struct packed {
        logic load_in;
        logic do_arrival;
        logic do_advance;
        logic do_place;
        logic do_result;
    } srpt_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic head_done;
    } srpt_status_t;

endpackage

>>> rtl/srpt_priority_queue.sv
// Top level of the shortest-remaining-time queue.
// Each transfer passes through load, head update (advance) or drop check
// (arrival), sorted insert into a shifting register array, and result
// capture, which waits until the previous result is taken. The result
// register lets the next item be taken while the previous result waits.
module srpt_priority_queue #(
    parameter int unsigned QUEUE_DEPTH = srpt_pkg::DefaultDepth
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [srpt_pkg::LenWidth-1:0]     msg_length,
    input  logic [srpt_pkg::ElapWidth-1:0]    elapsed,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              completed,
    output logic [srpt_pkg::TimeWidth-1:0]    latency,
    output logic [srpt_pkg::OccWidth-1:0]     occupancy,
    output logic [srpt_pkg::LenWidth-1:0]     head_length,
    output logic                              dropped,
    output logic                              overshoot,
    output logic [srpt_pkg::OccWidth-1:0]     peak_occupancy,
    output logic [srpt_pkg::StatWidth-1:0]    done_count,
    output logic [srpt_pkg::StatWidth-1:0]    latency_total,
    output logic [srpt_pkg::StatWidth-1:0]    occupancy_time
);
    import srpt_pkg::*;

    srpt_cmd_t    cmd;
    srpt_status_t status;

    srpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .ready     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .cmd       (cmd)
    );

    srpt_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .kind           (kind),
        .msg_length     (msg_length),
        .elapsed        (elapsed),
        .completed      (completed),
        .latency        (latency),
        .occupancy      (occupancy),
        .head_length    (head_length),
        .dropped        (dropped),
        .overshoot      (overshoot),
        .peak_occupancy (peak_occupancy),
        .done_count     (done_count),
        .latency_total  (latency_total),
        .occupancy_time (occupancy_time)
    );

endmodule

>>> rtl/srpt_dp.sv
// Datapath: sorted shift array, clock and statistics, result register.
module srpt_dp #(
    parameter int unsigned QUEUE_DEPTH = srpt_pkg::DefaultDepth
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  srpt_pkg::srpt_cmd_t               cmd,
    output srpt_pkg::srpt_status_t            status,
    input  logic                              kind,
    input  logic [srpt_pkg::LenWidth-1:0]     msg_length,
    input  logic [srpt_pkg::ElapWidth-1:0]    elapsed,
    output logic                              completed,
    output logic [srpt_pkg::TimeWidth-1:0]    latency,
    output logic [srpt_pkg::OccWidth-1:0]     occupancy,
    output logic [srpt_pkg::LenWidth-1:0]     head_length,
    output logic                              dropped,
    output logic                              overshoot,
    output logic [srpt_pkg::OccWidth-1:0]     peak_occupancy,
    output logic [srpt_pkg::StatWidth-1:0]    done_count,
    output logic [srpt_pkg::StatWidth-1:0]    latency_total,
    output logic [srpt_pkg::StatWidth-1:0]    occupancy_time
);
    import srpt_pkg::*;

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic [LenWidth-1:0]  rem_reg   [QUEUE_DEPTH];
    logic [TimeWidth-1:0] start_reg [QUEUE_DEPTH];
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        peak_reg;
    logic [TimeWidth-1:0] clock_reg;
    logic [StatWidth-1:0] done_reg, lat_acc_reg, occ_acc_reg;
    logic [StatWidth-1:0] occ_prod_reg;
    logic                 in_kind_reg;
    logic [LenWidth-1:0]  in_len_reg;
    logic [ElapWidth-1:0] in_elap_reg;
    logic                 place_reg;
    logic [LenWidth-1:0]  place_len_reg;
    logic [TimeWidth-1:0] place_start_reg;
    logic                 comp_reg, drop_reg, over_reg;
    logic [TimeWidth-1:0] lat_reg;
    logic [LenWidth-1:0]  new_rem;
    logic                 over_w;
    logic [TimeWidth-1:0] clk_adv;
    logic [QUEUE_DEPTH-1:0] le_vec;
    logic [ElapWidth+CW-1:0] occ_prod_w;

    assign status.full      = (count_reg >= CW'(QUEUE_DEPTH));
    assign status.empty     = (count_reg == '0);
    assign over_w           = {16'd0, in_elap_reg} > {{(ElapWidth){1'b0}}, rem_reg[0]};
    assign new_rem          = over_w ? '0 : rem_reg[0] - in_elap_reg[LenWidth-1:0];
    assign status.head_done = (new_rem == '0);
    assign clk_adv          = clock_reg + TimeWidth'(in_elap_reg);
    assign occ_prod_w       = in_elap_reg * count_reg;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            le_vec[i] = (CW'(i) < count_reg) && (rem_reg[i] <= place_len_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_kind_reg <= kind;
            in_len_reg  <= msg_length;
            in_elap_reg <= elapsed;
        end
        if (cmd.do_advance)
        begin
            occ_prod_reg <= StatWidth'(occ_prod_w);
        end
        if (cmd.do_arrival)
        begin
            place_len_reg   <= in_len_reg;
            place_start_reg <= clock_reg;
        end
        else if (cmd.do_advance && !status.empty)
        begin
            place_len_reg   <= new_rem;
            place_start_reg <= start_reg[0];
            lat_reg         <= clk_adv - start_reg[0];
            for (int i = 0; i + 1 < QUEUE_DEPTH; i++)
            begin
                rem_reg[i]   <= rem_reg[i+1];
                start_reg[i] <= start_reg[i+1];
            end
        end
        if (cmd.do_place && place_reg)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (!le_vec[i] && (i == 0 || le_vec[(i == 0) ? 0 : i-1]))
                begin
                    rem_reg[i]   <= place_len_reg;
                    start_reg[i] <= place_start_reg;
                end
                else if (!le_vec[i] && i > 0)
                begin
                    rem_reg[i]   <= rem_reg[(i == 0) ? 0 : i-1];
                    start_reg[i] <= start_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_advance && !status.empty)
            count_next = count_reg - CW'(1);
        if (cmd.do_place && place_reg)
            count_next = count_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            peak_reg    <= '0;
            clock_reg   <= '0;
            done_reg    <= '0;
            lat_acc_reg <= '0;
            occ_acc_reg <= '0;
            place_reg   <= 1'b0;
            comp_reg    <= 1'b0;
            drop_reg    <= 1'b0;
            over_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load_in)
            begin
                place_reg <= 1'b0;
                comp_reg  <= 1'b0;
                drop_reg  <= 1'b0;
                over_reg  <= 1'b0;
            end
            if (cmd.do_arrival)
            begin
                place_reg <= (in_len_reg != '0) && !status.full;
                drop_reg  <= (in_len_reg != '0) && status.full;
            end
            if (cmd.do_advance)
            begin
                clock_reg <= clk_adv;
                if (!status.empty)
                begin
                    over_reg  <= over_w;
                    comp_reg  <= status.head_done;
                    place_reg <= !status.head_done;
                    if (status.head_done)
                        done_reg <= done_reg + 64'd1;
                end
            end
            if (cmd.do_place)
            begin
                if (comp_reg)
                    lat_acc_reg <= lat_acc_reg + StatWidth'(lat_reg);
                if (in_kind_reg)
                    occ_acc_reg <= occ_acc_reg + occ_prod_reg;
                if (count_next > peak_reg)
                    peak_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_result)
        begin
            completed      <= comp_reg;
            latency        <= comp_reg ? lat_reg : '0;
            occupancy      <= OccWidth'(count_reg);
            head_length    <= status.empty ? '0 : rem_reg[0];
            dropped        <= drop_reg;
            overshoot      <= over_reg;
            peak_occupancy <= OccWidth'(peak_reg);
            done_count     <= done_reg;
            latency_total  <= lat_acc_reg;
            occupancy_time <= occ_acc_reg;
        end
    end

endmodule

>>> rtl/srpt_ctrl.sv
// Controller: sequences load, update, placement and result for one item.
module srpt_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid,
    output logic                    ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  logic                    kind,
    output srpt_pkg::srpt_cmd_t     cmd
);
    import srpt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_PLACE  = 5'b00100,
        ST_RESULT = 5'b01000,
        ST_HOLD   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   kind_reg;
    logic   ov_reg, ov_next;

    assign ready     = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_in = valid;
                if (valid)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.do_arrival = !kind_reg;
                cmd.do_advance = kind_reg;
                state_next     = ST_PLACE;
            end
            ST_PLACE:
            begin
                cmd.do_place = 1'b1;
                state_next   = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.do_result = 1'b1;
                    ov_next       = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_HOLD:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            kind_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (cmd.load_in)
                kind_reg <= kind;
        end
    end

endmodule

>>> verif/srpt_priority_queue_tb.sv
// Self-checking testbench for the shortest-remaining-time queue: directed table, fill and drain, then random.
`timescale 1ns / 100ps

module srpt_priority_queue_tb;

    import srpt_pkg::*;

    localparam int unsigned Depth     = DefaultDepth;
    localparam int unsigned StallLim  = 20000;
    localparam int unsigned RandItems = 600;
    localparam int unsigned HoldOff   = 400;

    typedef enum logic {
        KIND_ARRIVAL = 1'b0,
        KIND_ADVANCE = 1'b1
    } item_kind_e;

    typedef struct packed {
        logic                 completed;
        logic [TimeWidth-1:0] latency;
        logic [OccWidth-1:0]  occupancy;
        logic [LenWidth-1:0]  head_length;
        logic                 dropped;
        logic                 overshoot;
        logic [OccWidth-1:0]  peak_occupancy;
        logic [StatWidth-1:0] done_count;
        logic [StatWidth-1:0] latency_total;
        logic [StatWidth-1:0] occupancy_time;
    } queue_result_t;

    typedef struct {
        item_kind_e           kind;
        logic [LenWidth-1:0]  msg_length;
        logic [ElapWidth-1:0] elapsed;
        logic                 has_fixed;
        queue_result_t        fixed;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 kind;
    logic [LenWidth-1:0]  msg_length;
    logic [ElapWidth-1:0] elapsed;
    logic                 out_valid;
    logic                 out_ready;
    logic                 completed;
    logic [TimeWidth-1:0] latency;
    logic [OccWidth-1:0]  occupancy;
    logic [LenWidth-1:0]  head_length;
    logic                 dropped;
    logic                 overshoot;
    logic [OccWidth-1:0]  peak_occupancy;
    logic [StatWidth-1:0] done_count;
    logic [StatWidth-1:0] latency_total;
    logic [StatWidth-1:0] occupancy_time;

    srpt_priority_queue dut (.*);

    // shadow queue state
    logic [LenWidth-1:0]  q_rem[$];
    logic [TimeWidth-1:0] q_start[$];
    logic [TimeWidth-1:0] now_time;
    int unsigned          peak_seen;
    logic [StatWidth-1:0] done_seen;
    logic [StatWidth-1:0] lat_sum;
    logic [StatWidth-1:0] occ_sum;

    queue_result_t pending_results[$];
    queue_result_t fixed_results[$];
    logic          fixed_valid[$];
    int unsigned   error_count;
    bit            quiet_phase;
    bit            hold_req;
    int unsigned   idle_cycles;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic void sorted_insert(logic [LenWidth-1:0] len, logic [TimeWidth-1:0] st);
        int pos;
        pos = 0;
        while (pos < q_rem.size() && q_rem[pos] <= len)
            pos++;
        q_rem.insert(pos, len);
        q_start.insert(pos, st);
    endfunction

    function automatic queue_result_t srpt_step(item_kind_e k, logic [LenWidth-1:0] len,
                                                logic [ElapWidth-1:0] el);
        queue_result_t        r;
        logic [TimeWidth-1:0] st;
        logic [LenWidth-1:0]  rem;
        r = '0;
        if (k == KIND_ARRIVAL) begin
            if (len != 0) begin
                if (q_rem.size() >= Depth)
                    r.dropped = 1'b1;
                else
                    sorted_insert(len, now_time);
            end
        end
        else begin
            now_time = now_time + TimeWidth'(el);
            occ_sum  = occ_sum + StatWidth'(el) * StatWidth'(q_rem.size());
            if (q_rem.size() > 0) begin
                rem = q_rem.pop_front();
                st  = q_start.pop_front();
                if (32'(el) > 32'(rem)) begin
                    r.overshoot = 1'b1;
                    rem = '0;
                end
                else
                    rem = rem - LenWidth'(el);
                if (rem == 0) begin
                    r.completed = 1'b1;
                    r.latency   = now_time - st;
                    done_seen   = done_seen + 1;
                    lat_sum     = lat_sum + StatWidth'(r.latency);
                end
                else
                    sorted_insert(rem, st);
            end
        end
        if (q_rem.size() > peak_seen)
            peak_seen = q_rem.size();
        r.occupancy      = OccWidth'(q_rem.size());
        r.head_length    = q_rem.size() > 0 ? q_rem[0] : '0;
        r.peak_occupancy = OccWidth'(peak_seen);
        r.done_count     = done_seen;
        r.latency_total  = lat_sum;
        r.occupancy_time = occ_sum;
        return r;
    endfunction

    task automatic send_item(item_kind_e k, logic [LenWidth-1:0] len, logic [ElapWidth-1:0] el,
                             logic has_fixed, queue_result_t fx);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        msg_length <= len;
        elapsed    <= el;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(srpt_step(k, len, el));
        fixed_results.push_back(fx);
        fixed_valid.push_back(has_fixed);
    endtask

    task automatic check_field(string name, logic [StatWidth-1:0] exp_v, logic [StatWidth-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // receiver
    initial begin
        int gap;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HoldOff) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 13);
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk) begin
        queue_result_t e;
        queue_result_t fx;
        logic          use_fx;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no transfer waiting");
                error_count++;
            end
            else begin
                e      = pending_results.pop_front();
                fx     = fixed_results.pop_front();
                use_fx = fixed_valid.pop_front();
                if (use_fx && fx !== e) begin
                    $error("directed row disagrees with prediction");
                    error_count++;
                end
                check_field("completed", e.completed, completed);
                check_field("latency", e.latency, latency);
                check_field("occupancy", e.occupancy, occupancy);
                check_field("head_length", e.head_length, head_length);
                check_field("dropped", e.dropped, dropped);
                check_field("overshoot", e.overshoot, overshoot);
                check_field("peak_occupancy", e.peak_occupancy, peak_occupancy);
                check_field("done_count", e.done_count, done_count);
                check_field("latency_total", e.latency_total, latency_total);
                check_field("occupancy_time", e.occupancy_time, occupancy_time);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLim) begin
            $display("srpt_priority_queue verification failed");
            $finish;
        end
    end

    function automatic queue_result_t res(logic c, logic [TimeWidth-1:0] l, int occ, int hl,
                                          logic d, logic o, int pk, int dc, int lt, int ot);
        queue_result_t r;
        r.completed = c; r.latency = l; r.occupancy = OccWidth'(occ);
        r.head_length = LenWidth'(hl); r.dropped = d; r.overshoot = o;
        r.peak_occupancy = OccWidth'(pk); r.done_count = dc;
        r.latency_total = lt; r.occupancy_time = ot;
        return r;
    endfunction

    initial begin
        stim_row_t  rows[$];
        stim_row_t  row;
        item_kind_e k;
        int         wait_cnt;
        logic [ElapWidth-1:0] el;
        error_count = 0; quiet_phase = 0; hold_req = 0;
        idle_cycles = 0;
        now_time = '0; peak_seen = 0; done_seen = '0; lat_sum = '0; occ_sum = '0;
        rst_n = 1'b0; in_valid = 1'b0; kind = 1'b0; msg_length = '0; elapsed = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        rows.push_back('{KIND_ADVANCE, 16'd0, 32'd5, 1, res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        rows.push_back('{KIND_ARRIVAL, 16'd0, 32'hFFFFFFFF, 1,
                         res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        rows.push_back('{KIND_ARRIVAL, 16'hFFFF, 32'd0, 1,
                         res(0, 0, 1, 65535, 0, 0, 1, 0, 0, 0)});
        rows.push_back('{KIND_ARRIVAL, 16'd1, 32'd0, 1, res(0, 0, 2, 1, 0, 0, 2, 0, 0, 0)});
        rows.push_back('{KIND_ARRIVAL, 16'd1, 32'd0, 0, '0});
        rows.push_back('{KIND_ADVANCE, 16'd0, 32'd0, 0, '0});
        rows.push_back('{KIND_ADVANCE, 16'hFFFF, 32'd1, 0, '0});
        rows.push_back('{KIND_ADVANCE, 16'd0, 32'd100, 0, '0});
        rows.push_back('{KIND_ADVANCE, 16'd0, 32'hFFFFFFFF, 0, '0});
        rows.push_back('{KIND_ADVANCE, 16'd0, 32'hFFFFFFFF, 0, '0});
        rows.push_back('{KIND_ARRIVAL, 16'd8, 32'd0, 0, '0});
        rows.push_back('{KIND_ADVANCE, 16'd0, 32'd8, 0, '0});
        rows.push_back('{KIND_ADVANCE, 16'd0, 32'hAAAAAAAA, 0, '0});
        rows.push_back('{KIND_ADVANCE, 16'd0, 32'h55555555, 0, '0});
        foreach (rows[i]) begin
            row = rows[i];
            send_item(row.kind, row.msg_length, row.elapsed, row.has_fixed, row.fixed);
        end

        // fill past full while the receiver holds off, then drain by advances
        hold_req = 1'b1;
        repeat (Depth + 4)
            send_item(KIND_ARRIVAL, LenWidth'($urandom_range(1, 65535)), $urandom, 0, '0);
        repeat (Depth + 4)
            send_item(KIND_ADVANCE, LenWidth'($urandom),
                      32'hFFFF_FFFF - $urandom_range(0, 3), 0, '0);

        // random: mostly small lengths and elapsed so entries reorder and tie
        for (int n = 0; n < RandItems; n++) begin
            if (n > RandItems - 80)
                quiet_phase = 1'b1;
            k = $urandom_range(0, 99) < 55 ? KIND_ARRIVAL : KIND_ADVANCE;
            case ($urandom_range(0, 9))
                0:       el = $urandom;
                1:       el = '0;
                default: el = $urandom_range(0, 12);
            endcase
            send_item(k, ($urandom_range(0, 9) == 0) ? LenWidth'($urandom)
                                                     : LenWidth'($urandom_range(0, 12)),
                      el, 0, '0);
        end
        in_valid <= 1'b0;

        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < StallLim) begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("srpt_priority_queue verification clean");
        else
            $display("srpt_priority_queue verification failed");
        $finish;
    end

endmodule
